@@ sv/chie_pkg.sv @@
// shared types and constants of the chained hash index engine
package chie_pkg;

  localparam int BUCKETS  = 1024;
  localparam int ENTRIES  = 1024;
  localparam int MAX_HITS = 16;

  localparam int BKT_W = $clog2(BUCKETS);
  localparam int ENT_W = $clog2(ENTRIES);
  localparam int CNT_W = ENT_W + 1;

  localparam logic [31:0] DJB2_SEED = 32'd5381;
  localparam int          DJB2_SHIFT = 5;

  localparam logic [1:0] REG_BUCKET_COUNT = 2'd0;
  localparam logic [1:0] REG_KEY_MODE     = 2'd1;

  localparam logic [1:0] MODE_INT  = 2'd0;
  localparam logic [1:0] MODE_TIME = 2'd1;
  localparam logic [1:0] MODE_BOOL = 2'd2;

  localparam logic [1:0] KIND_INSERTED = 2'd0;
  localparam logic [1:0] KIND_FULL     = 2'd1;
  localparam logic [1:0] KIND_MATCH    = 2'd2;
  localparam logic [1:0] KIND_NOMATCH  = 2'd3;

  localparam logic ACT_INSERT = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_HREAD,
    ST_HUSE,
    ST_EREAD,
    ST_ECHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [ENT_W-1:0] idx;
  } link_t;

  typedef struct packed {
    logic [63:0] key;
    logic [30:0] pos;
    link_t       link;
  } entry_t;

endpackage

@@ sv/chained_hash_index_engine.sv @@
// chained hash index engine: djb2 hash, bucket heads and entry pool in memories
//
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  action, key, position, max_hits
// out      out  out_valid/out_stall kind, found_position, match_number, last
// cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// an insert runs 1 or 8 hash steps (8 in time mode), then 32 steps of the bit-serial modulo,
// a head read and an update step that gives its result.
// a find then walks the chain with a read and a check step per entry, and a finish step gives its final result.
// after reset a clearing pass writes every bucket head; no item is taken during it.
// a waiting result holds the walk at its next emit; one input item is taken at a time.
module chained_hash_index_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic signed [63:0] in_key,
  input  logic [30:0]        in_position,
  input  logic [4:0]         in_max_hits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [30:0]        out_found_position,
  output logic [4:0]         out_match_number,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data
);

  localparam int BKT_W = chie_pkg::BKT_W;
  localparam int ENT_W = chie_pkg::ENT_W;
  localparam int CNT_W = chie_pkg::CNT_W;

  chie_pkg::link_t  heads [chie_pkg::BUCKETS];
  chie_pkg::entry_t pool  [chie_pkg::ENTRIES];

  chie_pkg::state_t state_r, state_nxt;
  logic [10:0]       bcount_r, bcount_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [BKT_W-1:0]  clr_r, clr_nxt;
  logic              act_r, act_nxt;
  logic [63:0]       key_r, key_nxt;
  logic [30:0]       pos_r, pos_nxt;
  logic [4:0]        limit_r, limit_nxt;
  logic [31:0]       h_r, h_nxt;
  logic [2:0]        hcnt_r, hcnt_nxt;
  logic [4:0]        dcnt_r, dcnt_nxt;
  logic [BKT_W-1:0]  rem_r, rem_nxt;
  logic [ENT_W-1:0]  cur_r, cur_nxt;
  logic [4:0]        count_r, count_nxt;
  logic [30:0]       pend_r, pend_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic [30:0]       out_pos_r, out_pos_nxt;
  logic [4:0]        out_num_r, out_num_nxt;
  logic              out_last_r, out_last_nxt;

  chie_pkg::link_t  head_q;
  chie_pkg::entry_t ent_q;

  logic              head_we;
  logic [BKT_W-1:0]  head_wa;
  chie_pkg::link_t   head_wd;
  logic              ent_we;

  logic [1:0]        mode_use;
  logic [10:0]       nbkt;
  logic [7:0]        hbyte;
  logic [31:0]       hval;
  logic [BKT_W:0]    trial;
  logic              key_eq;
  logic              out_free;
  logic [4:0]        count_inc;

  always_comb begin
    mode_use = (mode_r == chie_pkg::MODE_TIME || mode_r == chie_pkg::MODE_BOOL) ?
               mode_r : chie_pkg::MODE_INT;
    if (bcount_r == 11'd0) begin
      nbkt = 11'd1;
    end else if (bcount_r > 11'(chie_pkg::BUCKETS)) begin
      nbkt = 11'(chie_pkg::BUCKETS);
    end else begin
      nbkt = bcount_r;
    end
    hbyte = key_r[8*hcnt_r +: 8];
    case (mode_use)
      chie_pkg::MODE_TIME: hval = {24'd0, hbyte};
      chie_pkg::MODE_BOOL: hval = {31'd0, |key_r};
      default:             hval = key_r[31:0];
    endcase
    trial = {rem_r, h_r[dcnt_r]};
    case (mode_use)
      chie_pkg::MODE_TIME: key_eq = (ent_q.key == key_r);
      chie_pkg::MODE_BOOL: key_eq = ((|ent_q.key) == (|key_r));
      default:             key_eq = (ent_q.key[31:0] == key_r[31:0]);
    endcase
    out_free  = !out_valid_r || !out_stall;
    count_inc = count_r + 5'd1;
  end

  always_comb begin
    state_nxt     = state_r;
    bcount_nxt    = bcount_r;
    mode_nxt      = mode_r;
    used_nxt      = used_r;
    clr_nxt       = clr_r;
    act_nxt       = act_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    limit_nxt     = limit_r;
    h_nxt         = h_r;
    hcnt_nxt      = hcnt_r;
    dcnt_nxt      = dcnt_r;
    rem_nxt       = rem_r;
    cur_nxt       = cur_r;
    count_nxt     = count_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_pos_nxt   = out_pos_r;
    out_num_nxt   = out_num_r;
    out_last_nxt  = out_last_r;
    head_we       = 1'b0;
    head_wa       = rem_r;
    head_wd       = '0;
    ent_we        = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        chie_pkg::REG_BUCKET_COUNT: bcount_nxt = cfg_data;
        chie_pkg::REG_KEY_MODE:     mode_nxt   = cfg_data[1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      chie_pkg::ST_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BKT_W'(chie_pkg::BUCKETS - 1)) begin
          state_nxt = chie_pkg::ST_IDLE;
        end
      end
      chie_pkg::ST_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_action;
          key_nxt   = in_key;
          pos_nxt   = in_position;
          limit_nxt = (in_max_hits > 5'(chie_pkg::MAX_HITS)) ?
                      5'(chie_pkg::MAX_HITS) : in_max_hits;
          h_nxt     = chie_pkg::DJB2_SEED;
          hcnt_nxt  = 3'd0;
          state_nxt = chie_pkg::ST_HASH;
        end
      end
      chie_pkg::ST_HASH: begin
        h_nxt    = (h_r << chie_pkg::DJB2_SHIFT) + h_r + hval;
        hcnt_nxt = hcnt_r + 3'd1;
        if (mode_use != chie_pkg::MODE_TIME || hcnt_r == 3'd7) begin
          dcnt_nxt  = 5'd31;
          rem_nxt   = '0;
          state_nxt = chie_pkg::ST_MOD;
        end
      end
      chie_pkg::ST_MOD: begin
        if (11'(trial) >= nbkt) begin
          rem_nxt = BKT_W'(11'(trial) - nbkt);
        end else begin
          rem_nxt = BKT_W'(trial);
        end
        dcnt_nxt = dcnt_r - 5'd1;
        if (dcnt_r == 5'd0) begin
          state_nxt = chie_pkg::ST_HREAD;
        end
      end
      chie_pkg::ST_HREAD: begin
        count_nxt = 5'd0;
        state_nxt = chie_pkg::ST_HUSE;
      end
      chie_pkg::ST_HUSE: begin
        if (act_r == chie_pkg::ACT_INSERT) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_pos_nxt   = '0;
            out_num_nxt   = '0;
            out_last_nxt  = 1'b1;
            if (used_r >= CNT_W'(chie_pkg::ENTRIES)) begin
              out_kind_nxt = chie_pkg::KIND_FULL;
            end else begin
              out_kind_nxt  = chie_pkg::KIND_INSERTED;
              ent_we        = 1'b1;
              head_we       = 1'b1;
              head_wd.valid = 1'b1;
              head_wd.idx   = used_r[ENT_W-1:0];
              used_nxt      = used_r + 1'b1;
            end
            state_nxt = chie_pkg::ST_IDLE;
          end
        end else if (limit_r == 5'd0 || !head_q.valid) begin
          state_nxt = chie_pkg::ST_FINISH;
        end else begin
          cur_nxt   = head_q.idx;
          state_nxt = chie_pkg::ST_EREAD;
        end
      end
      chie_pkg::ST_EREAD: begin
        state_nxt = chie_pkg::ST_ECHECK;
      end
      chie_pkg::ST_ECHECK: begin
        if (key_eq) begin
          if (count_r == 5'd0 || out_free) begin
            if (count_r != 5'd0) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = chie_pkg::KIND_MATCH;
              out_pos_nxt   = pend_r;
              out_num_nxt   = count_r;
              out_last_nxt  = 1'b0;
            end
            pend_nxt  = ent_q.pos;
            count_nxt = count_inc;
            cur_nxt   = ent_q.link.idx;
            if (count_inc == limit_r || !ent_q.link.valid) begin
              state_nxt = chie_pkg::ST_FINISH;
            end else begin
              state_nxt = chie_pkg::ST_EREAD;
            end
          end
        end else begin
          cur_nxt   = ent_q.link.idx;
          state_nxt = ent_q.link.valid ? chie_pkg::ST_EREAD : chie_pkg::ST_FINISH;
        end
      end
      chie_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (count_r == 5'd0) begin
            out_kind_nxt = chie_pkg::KIND_NOMATCH;
            out_pos_nxt  = '0;
            out_num_nxt  = '0;
          end else begin
            out_kind_nxt = chie_pkg::KIND_MATCH;
            out_pos_nxt  = pend_r;
            out_num_nxt  = count_r;
          end
          state_nxt = chie_pkg::ST_IDLE;
        end
      end
      default: state_nxt = chie_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      heads[head_wa] <= head_wd;
    end
    head_q <= heads[rem_r];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      pool[used_r[ENT_W-1:0]] <= '{key: key_r, pos: pos_r, link: head_q};
    end
    ent_q <= pool[cur_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chie_pkg::ST_CLEAR;
      bcount_r    <= 11'(chie_pkg::BUCKETS);
      mode_r      <= chie_pkg::MODE_INT;
      used_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bcount_r    <= bcount_nxt;
      mode_r      <= mode_nxt;
      used_r      <= used_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    pos_r      <= pos_nxt;
    limit_r    <= limit_nxt;
    h_r        <= h_nxt;
    hcnt_r     <= hcnt_nxt;
    dcnt_r     <= dcnt_nxt;
    rem_r      <= rem_nxt;
    cur_r      <= cur_nxt;
    count_r    <= count_nxt;
    pend_r     <= pend_nxt;
    out_kind_r <= out_kind_nxt;
    out_pos_r  <= out_pos_nxt;
    out_num_r  <= out_num_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall           = (state_r != chie_pkg::ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_found_position = out_pos_r;
  assign out_match_number   = out_num_r;
  assign out_last           = out_last_r;

endmodule

@@ bench/hash_index_checker.sv @@
// checker for the chained hash index engine: predicts results and compares them
`timescale 1ns / 100ps
module hash_index_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [63:0] in_key,
  input  logic [30:0] in_position,
  input  logic [4:0]  in_max_hits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [30:0] out_found_position,
  input  logic [4:0]  out_match_number,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [30:0] pos;
    logic [4:0]  num;
    logic        last;
  } hit_t;

  hit_t                      hits_due[$];
  logic [10:0]               bucket_reg;
  logic [1:0]                mode_reg;
  logic [chie_pkg::ENT_W-1:0] head_idx[chie_pkg::BUCKETS];
  bit                        head_ok[chie_pkg::BUCKETS];
  logic [63:0]               ent_key[chie_pkg::ENTRIES];
  logic [30:0]               ent_pos[chie_pkg::ENTRIES];
  logic [chie_pkg::ENT_W-1:0] ent_next[chie_pkg::ENTRIES];
  bit                        ent_next_ok[chie_pkg::ENTRIES];
  int                        pool_used;

  function automatic logic [1:0] eff_mode();
    return (mode_reg == chie_pkg::MODE_TIME || mode_reg == chie_pkg::MODE_BOOL) ?
           mode_reg : chie_pkg::MODE_INT;
  endfunction

  function automatic logic [31:0] djb2(logic [63:0] k);
    logic [31:0] h;
    h = chie_pkg::DJB2_SEED;
    if (eff_mode() == chie_pkg::MODE_TIME) begin
      for (int i = 0; i < 8; i++)
        h = (h << chie_pkg::DJB2_SHIFT) + h + 32'(k[8*i +: 8]);
    end else if (eff_mode() == chie_pkg::MODE_BOOL) begin
      h = (h << chie_pkg::DJB2_SHIFT) + h + 32'(k != 0);
    end else begin
      h = (h << chie_pkg::DJB2_SHIFT) + h + k[31:0];
    end
    return h;
  endfunction

  function automatic bit same_key(logic [63:0] a, logic [63:0] b);
    if (eff_mode() == chie_pkg::MODE_TIME) return a == b;
    if (eff_mode() == chie_pkg::MODE_BOOL) return (a != 0) == (b != 0);
    return a[31:0] == b[31:0];
  endfunction

  task automatic predict_item();
    int   nb, bkt, lim, count, steps;
    bit   ok;
    int   cur;
    hit_t h;
    nb = (bucket_reg == 0) ? 1 :
         (bucket_reg > chie_pkg::BUCKETS) ? chie_pkg::BUCKETS : int'(bucket_reg);
    bkt = int'(djb2(in_key) % nb);
    if (in_action == chie_pkg::ACT_INSERT) begin
      if (pool_used >= chie_pkg::ENTRIES) begin
        h = '{chie_pkg::KIND_FULL, 31'd0, 5'd0, 1'b1};
      end else begin
        ent_key[pool_used] = in_key;
        ent_pos[pool_used] = in_position;
        ent_next[pool_used] = head_idx[bkt];
        ent_next_ok[pool_used] = head_ok[bkt];
        head_idx[bkt] = chie_pkg::ENT_W'(pool_used);
        head_ok[bkt] = 1;
        pool_used++;
        h = '{chie_pkg::KIND_INSERTED, 31'd0, 5'd0, 1'b1};
      end
      hits_due.push_back(h);
    end else begin
      lim = (in_max_hits > chie_pkg::MAX_HITS) ? chie_pkg::MAX_HITS : int'(in_max_hits);
      count = 0;
      steps = 0;
      ok = head_ok[bkt];
      cur = int'(head_idx[bkt]);
      while (ok && count < lim && steps < chie_pkg::ENTRIES) begin
        if (same_key(ent_key[cur], in_key)) begin
          count++;
          hits_due.push_back('{chie_pkg::KIND_MATCH, ent_pos[cur], 5'(count), 1'b0});
        end
        ok = ent_next_ok[cur];
        cur = int'(ent_next[cur]);
        steps++;
      end
      if (count == 0) hits_due.push_back('{chie_pkg::KIND_NOMATCH, 31'd0, 5'd0, 1'b1});
      else hits_due[$].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    hit_t want;
    if (!rst_n) begin
      bucket_reg <= 11'd1024;
      mode_reg <= chie_pkg::MODE_INT;
      pool_used = 0;
      for (int i = 0; i < chie_pkg::BUCKETS; i++) head_ok[i] = 0;
      hits_due.delete();
      errors = 0;
      outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == chie_pkg::REG_BUCKET_COUNT) bucket_reg <= cfg_data;
        else if (cfg_index == chie_pkg::REG_KEY_MODE) mode_reg <= cfg_data[1:0];
      end
      if (in_valid && !in_stall) predict_item();
      if (out_valid && !out_stall) begin
        if (hits_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result kind %0d pos %0d num %0d last %0d",
                                     out_kind, out_found_position, out_match_number, out_last);
        end else begin
          want = hits_due.pop_front();
          if (want.kind != out_kind || want.pos != out_found_position ||
              want.num != out_match_number || want.last != out_last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected kind %0d pos %0d num %0d last %0d, got %0d %0d %0d %0d",
                       want.kind, want.pos, want.num, want.last, out_kind,
                       out_found_position, out_match_number, out_last);
          end
        end
      end
      outstanding = hits_due.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
// top of the bench: clock, reset, stimulus, receiver stalls, watchdog and verdict
`timescale 1ns / 100ps
module testbench;

  localparam logic       ACT_FIND    = ~chie_pkg::ACT_INSERT;
  localparam logic [1:0] REG_SPARE0  = 2'd2;
  localparam logic [1:0] REG_SPARE1  = 2'd3;
  localparam int         WATCH_LIMIT = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_action;
  logic signed [63:0] in_key;
  logic [30:0]        in_position;
  logic [4:0]         in_max_hits;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_kind;
  logic [30:0]        out_found_position;
  logic [4:0]         out_match_number;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [10:0]        cfg_data;
  int                 errors;
  int                 outstanding;
  bit                 quiet;
  bit                 hold_req;
  logic [1:0]         cur_mode;
  logic [63:0]        key_pool[8];
  int                 idle_count;

  chained_hash_index_engine u_top (.*);

  hash_index_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_stall = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 24);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCH_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic send(logic act, logic [63:0] k, logic [30:0] pos, logic [4:0] hits);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 24) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_action <= act;
    in_key <= k;
    in_position <= pos;
    in_max_hits <= hits;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    in_valid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == chie_pkg::REG_KEY_MODE) cur_mode = val[1:0];
  endtask

  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      k = key_pool[$urandom_range(0, 7)];
      if (r < 15) k[63:32] = $urandom;
    end else if (r < 65) begin
      k = 64'h0;
    end else if (r < 70) begin
      k = '1;
    end else begin
      k = {$urandom, $urandom};
    end
    if (cur_mode == chie_pkg::MODE_BOOL && $urandom_range(0, 99) < 30) k = 64'h0;
    return k;
  endfunction

  task automatic random_items(int n);
    logic [4:0] hits;
    for (int i = 0; i < n; i++) begin
      hits = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
      send($urandom_range(0, 1) ? ACT_FIND : chie_pkg::ACT_INSERT, pick_key(),
           31'($urandom), hits);
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_action = chie_pkg::ACT_INSERT;
    in_key = 0;
    in_position = 0;
    in_max_hits = 0;
    cfg_valid = 0;
    cfg_index = chie_pkg::REG_BUCKET_COUNT;
    cfg_data = 0;
    quiet = 0;
    hold_req = 0;
    cur_mode = chie_pkg::MODE_INT;
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // integer keys, extremes and upper-half aliasing
    send(chie_pkg::ACT_INSERT, 64'h8000_0000_0000_0000, 31'd0, 5'd0);
    send(chie_pkg::ACT_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 5'd31);
    send(chie_pkg::ACT_INSERT, 64'h0, 31'd5, 5'd1);
    send(chie_pkg::ACT_INSERT, 64'hFFFF_FFFF_0000_0000, 31'd6, 5'd16);
    send(ACT_FIND, 64'h0, 31'd0, 5'd16);
    send(ACT_FIND, 64'h0, 31'h7FFF_FFFF, 5'd1);
    send(ACT_FIND, 64'h0, 31'd0, 5'd0);
    send(ACT_FIND, 64'h0, 31'd0, 5'd31);
    send(ACT_FIND, 64'd12345, 31'd0, 5'd16);
    // time and bool keys with old entries compared under the new mode, then out-of-range and spare register writes
    write_reg(chie_pkg::REG_KEY_MODE, 11'(chie_pkg::MODE_TIME));
    send(chie_pkg::ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 31'd7, 5'd0);
    send(ACT_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 31'd0, 5'd16);
    send(ACT_FIND, 64'h0, 31'd0, 5'd16);
    write_reg(chie_pkg::REG_KEY_MODE, 11'(chie_pkg::MODE_BOOL));
    send(chie_pkg::ACT_INSERT, 64'h0, 31'd8, 5'd0);
    send(chie_pkg::ACT_INSERT, 64'h1, 31'd9, 5'd0);
    send(ACT_FIND, 64'h5, 31'd0, 5'd16);
    send(ACT_FIND, 64'h0, 31'd0, 5'd16);
    write_reg(chie_pkg::REG_KEY_MODE, 11'h7FF);
    send(ACT_FIND, 64'h0, 31'd0, 5'd16);
    write_reg(chie_pkg::REG_BUCKET_COUNT, 11'd0);
    send(chie_pkg::ACT_INSERT, 64'd7, 31'd10, 5'd0);
    send(ACT_FIND, 64'd7, 31'd0, 5'd16);
    write_reg(chie_pkg::REG_BUCKET_COUNT, 11'h7FF);
    send(ACT_FIND, 64'h0, 31'd0, 5'd16);
    write_reg(REG_SPARE0, 11'h555);
    write_reg(REG_SPARE1, 11'h2AA);

    // random phases under varied settings
    write_reg(chie_pkg::REG_BUCKET_COUNT, 11'd1);
    write_reg(chie_pkg::REG_KEY_MODE, 11'(chie_pkg::MODE_INT));
    hold_req = 1;
    random_items(20);
    write_reg(chie_pkg::REG_BUCKET_COUNT, 11'd7);
    write_reg(chie_pkg::REG_KEY_MODE, 11'(chie_pkg::MODE_TIME));
    quiet = 1;
    random_items(20);
    quiet = 0;
    write_reg(chie_pkg::REG_BUCKET_COUNT, 11'd1024);
    write_reg(chie_pkg::REG_KEY_MODE, 11'(chie_pkg::MODE_BOOL));
    random_items(20);
    write_reg(chie_pkg::REG_BUCKET_COUNT, 11'($urandom_range(2, 1023)));
    write_reg(chie_pkg::REG_KEY_MODE, 11'(chie_pkg::MODE_INT));
    random_items(20);

    // few buckets, long chain walks
    write_reg(chie_pkg::REG_BUCKET_COUNT, 11'd3);
    random_items(12);
    in_valid <= 0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
